>>> src/fractal_value_noise_biome_map_assert.svh
// ----------------------------------------------------------------------------
// fractal_value_noise_biome_map_assert
// Assertion macros shared by the noise biome block.
// Each macro expects clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef FRACTAL_VALUE_NOISE_BIOME_MAP_ASSERT_SVH
`define FRACTAL_VALUE_NOISE_BIOME_MAP_ASSERT_SVH

// same-cycle implication
`define FVNB_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FVNB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/fvnb_pkg.sv
// ----------------------------------------------------------------------------
// fvnb_pkg
// Types, register indexes, hash constants and the biome ROM of the noise biome block.
// ----------------------------------------------------------------------------
package fvnb_pkg;

  localparam int COORD_BITS = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_SEED    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_FREQ   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 2'd3;

  localparam logic [31:0] HASH_MUL_Y    = 32'd57;
  localparam logic [31:0] HASH_MUL_SEED = 32'd131;
  localparam logic [31:0] HASH_MUL_SQ   = 32'd15731;
  localparam logic [31:0] HASH_ADD_SQ   = 32'd789221;
  localparam logic [31:0] HASH_ADD_OUT  = 32'd1376312589;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] tile_x;
    logic signed [COORD_BITS-1:0] tile_y;
  } in_item_t;

  typedef struct packed {
    logic [2:0] biome_code;
    logic [2:0] height_level;
    logic [2:0] temp_level;
  } out_item_t;

  // indexed by {temp_level, height_level}
  localparam logic [2:0] BIOME_ROM [64] = '{
    3'd5, 3'd5, 3'd5, 3'd6, 3'd6, 3'd2, 3'd2, 3'd2,
    3'd7, 3'd5, 3'd5, 3'd6, 3'd6, 3'd6, 3'd2, 3'd2,
    3'd7, 3'd5, 3'd0, 3'd0, 3'd6, 3'd6, 3'd2, 3'd2,
    3'd7, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd2,
    3'd7, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd4,
    3'd7, 3'd7, 3'd0, 3'd0, 3'd1, 3'd1, 3'd4, 3'd4,
    3'd7, 3'd7, 3'd0, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4,
    3'd7, 3'd7, 3'd7, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4
  };

endpackage

>>> src/fvnb_front.sv
// ----------------------------------------------------------------------------
// fvnb_front
// Absolute tile coordinates scaled by the base frequency, one register stage.
// ----------------------------------------------------------------------------
module fvnb_front #(
  parameter int FRAC_BITS = 16,
  parameter int BX_W      = 40
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [15:0]              freq_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  fvnb_pkg::in_item_t       in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [BX_W-1:0]          bx_o,
  output logic [BX_W-1:0]          by_o
);

  localparam int CB = fvnb_pkg::COORD_BITS;
  localparam int PW = CB + 16;

  logic          valid_q;
  logic [CB-1:0] ax, ay;
  logic [PW-1:0] px, py;
  logic [BX_W-1:0] bx_d, by_d, bx_q, by_q;

  // the most negative value maps onto itself, read as unsigned
  assign ax = in_item_i.tile_x[CB-1] ? (CB'(0) - CB'(in_item_i.tile_x)) : CB'(in_item_i.tile_x);
  assign ay = in_item_i.tile_y[CB-1] ? (CB'(0) - CB'(in_item_i.tile_y)) : CB'(in_item_i.tile_y);
  assign px = PW'(ax) * PW'(freq_i);
  assign py = PW'(ay) * PW'(freq_i);

  if (FRAC_BITS >= 16) begin : g_up
    assign bx_d = BX_W'(px) << (FRAC_BITS - 16);
    assign by_d = BX_W'(py) << (FRAC_BITS - 16);
  end else begin : g_dn
    assign bx_d = BX_W'(px >> (16 - FRAC_BITS));
    assign by_d = BX_W'(py >> (16 - FRAC_BITS));
  end

  assign in_ready_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      bx_q <= bx_d;
      by_q <= by_d;
    end
  end

  assign out_valid_o = valid_q;
  assign bx_o        = bx_q;
  assign by_o        = by_q;

endmodule

>>> src/fvnb_cell.sv
// ----------------------------------------------------------------------------
// fvnb_cell
// One octave of both noise fields: lattice hash, smoothstep, bilinear blend
// and accumulation, seven register stages deep.
// ----------------------------------------------------------------------------
module fvnb_cell #(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 16,
  parameter int OCT         = 0,
  parameter int BX_W        = 40,
  parameter int ACC_W       = 35,
  parameter int NW          = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [NW-1:0]           n_i,
  input  logic [31:0]             hseed_i,
  input  logic [31:0]             tseed_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [BX_W-1:0]         bx_i,
  input  logic [BX_W-1:0]         by_i,
  input  logic signed [ACC_W-1:0] acch_i,
  input  logic signed [ACC_W-1:0] acct_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [BX_W-1:0]         bx_o,
  output logic [BX_W-1:0]         by_o,
  output logic signed [ACC_W-1:0] acch_o,
  output logic signed [ACC_W-1:0] acct_o
);

  localparam int F    = FRAC_BITS;
  localparam int NS   = 7;
  localparam int SW   = (BX_W + OCT + 1 > F + 32) ? (BX_W + OCT + 1) : (F + 32);
  localparam int LW   = F + 2;
  localparam int PW   = 2 * F + 5;
  localparam int ONE  = 1 << F;
  localparam int C11  = ((11 << F) + 5) / 10;
  localparam int SH_T = 2 * MAX_OCTAVES - 2 - OCT;
  localparam int SH_O = 2 * MAX_OCTAVES - 2 - 2 * OCT;
  localparam logic [F+1:0] THREE = (F + 2)'(3) << F;
  localparam logic signed [ACC_W-1:0] ONE_T = ACC_W'(1) << (SH_O + F);

  // pipeline control
  logic [NS-1:0] vld_q;
  logic [NS-1:0] vin;
  logic [NS:0]   rdy;

  assign rdy[NS] = out_ready_i;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = ~vld_q[k] | rdy[k+1];
  end
  assign vin = {vld_q[NS-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) vld_q[k] <= vin[k];
      end
    end
  end

  // ---- stage 0: lattice coordinates, hash prefix, s^2
  logic [SW-1:0]    px, py;
  logic [31:0]      xi, yi;
  logic [F-1:0]     fx, fy;
  logic [2*F-1:0]   ppx, ppy;
  logic [31:0]      h0_d [8];

  assign px  = SW'(bx_i) << OCT;
  assign py  = SW'(by_i) << OCT;
  assign xi  = px[F+31:F];
  assign yi  = py[F+31:F];
  assign fx  = px[F-1:0];
  assign fy  = py[F-1:0];
  assign ppx = (2 * F)'(fx) * (2 * F)'(fx);
  assign ppy = (2 * F)'(fy) * (2 * F)'(fy);

  // hash k: bit 0 is the x corner, bit 1 the y corner, bit 2 the field
  always_comb begin
    logic [31:0] hx, hy, nn;
    for (int k = 0; k < 8; k++) begin
      hx = xi + 32'(k & 1);
      hy = yi + 32'((k >> 1) & 1);
      nn = hx + hy * fvnb_pkg::HASH_MUL_Y + ((k < 4) ? hseed_i : tseed_i);
      h0_d[k] = nn ^ (nn << 13);
    end
  end

  logic [31:0]  h0_q [8];
  logic [F-1:0] fx0_q, fy0_q, s2x0_q, s2y0_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      h0_q   <= h0_d;
      fx0_q  <= fx;
      fy0_q  <= fy;
      s2x0_q <= ppx[2*F-1:F];
      s2y0_q <= ppy[2*F-1:F];
    end
  end

  // ---- stage 1: h*h, smoothstep weights
  logic [F+1:0]   gx, gy;
  logic [2*F+1:0] pwx, pwy;
  logic [31:0]    h1_q [8];
  logic [31:0]    sq1_q [8];
  logic [F:0]     wx1_q, wy1_q;

  assign gx  = THREE - (F + 2)'({fx0_q, 1'b0});
  assign gy  = THREE - (F + 2)'({fy0_q, 1'b0});
  assign pwx = (2 * F + 2)'(s2x0_q) * (2 * F + 2)'(gx);
  assign pwy = (2 * F + 2)'(s2y0_q) * (2 * F + 2)'(gy);

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      for (int k = 0; k < 8; k++) begin
        sq1_q[k] <= h0_q[k] * h0_q[k];
        h1_q[k]  <= h0_q[k];
      end
      wx1_q <= pwx[2*F:F];
      wy1_q <= pwy[2*F:F];
    end
  end

  // ---- stage 2: polynomial term
  logic [31:0] h2_q [8];
  logic [31:0] t2_q [8];
  logic [F:0]  wx2_q, wy2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      for (int k = 0; k < 8; k++) begin
        t2_q[k] <= sq1_q[k] * fvnb_pkg::HASH_MUL_SQ + fvnb_pkg::HASH_ADD_SQ;
        h2_q[k] <= h1_q[k];
      end
      wx2_q <= wx1_q;
      wy2_q <= wy1_q;
    end
  end

  // ---- stage 3: final hash and lattice value 1 - m/2^30
  logic [31:0]           m3 [8];
  logic signed [LW-1:0]  l3_q [8];
  logic [F:0]            wx3_q, wy3_q;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      m3[k] = h2_q[k] * t2_q[k] + fvnb_pkg::HASH_ADD_OUT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      for (int k = 0; k < 8; k++) begin
        l3_q[k] <= LW'(ONE) - LW'(m3[k][30:30-F]);
      end
      wx3_q <= wx2_q;
      wy3_q <= wy2_q;
    end
  end

  // ---- stage 4: x blend products; j = 2*field + row
  logic signed [LW:0]    d4 [4];
  logic signed [PW-1:0]  p4_q [4];
  logic signed [LW-1:0]  a4_q [4];
  logic [F:0]            wy4_q;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      d4[j] = (LW + 1)'(l3_q[2*j+1]) - (LW + 1)'(l3_q[2*j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      for (int j = 0; j < 4; j++) begin
        p4_q[j] <= PW'(d4[j]) * PW'($signed({1'b0, wx3_q}));
        a4_q[j] <= l3_q[2*j];
      end
      wy4_q <= wy3_q;
    end
  end

  // ---- stage 5: rows done, y blend product
  logic signed [LW:0]   lo5w [2];
  logic signed [LW:0]   hi5w [2];
  logic signed [LW:0]   d5 [2];
  logic signed [LW-1:0] lo5_q [2];
  logic signed [PW-1:0] p5_q [2];

  // floor division by 2^F: arithmetic shift also covers the negative side
  always_comb begin
    for (int f = 0; f < 2; f++) begin
      lo5w[f] = (LW + 1)'(a4_q[2*f])   + (LW + 1)'(p4_q[2*f] >>> F);
      hi5w[f] = (LW + 1)'(a4_q[2*f+1]) + (LW + 1)'(p4_q[2*f+1] >>> F);
      d5[f]   = hi5w[f] - lo5w[f];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      for (int f = 0; f < 2; f++) begin
        lo5_q[f] <= $signed(lo5w[f][LW-1:0]);
        p5_q[f]  <= PW'(d5[f]) * PW'($signed({1'b0, wy4_q}));
      end
    end
  end

  // ---- stage 6: noise value, octave term into the sums
  logic signed [LW:0]    nz6 [2];
  logic signed [LW:0]    t6 [2];
  logic signed [ACC_W-1:0] term6 [2];
  logic                  oct_on;

  assign oct_on = int'(n_i) > OCT;

  always_comb begin
    for (int f = 0; f < 2; f++) begin
      nz6[f]   = (LW + 1)'(lo5_q[f]) + (LW + 1)'(p5_q[f] >>> F);
      t6[f]    = nz6[f] + (LW + 1)'(C11);
      term6[f] = oct_on ? ((ACC_W'(t6[f]) <<< SH_T) - ONE_T) : '0;
    end
  end

  // pass-through payload
  logic [BX_W-1:0]         bx_q [NS];
  logic [BX_W-1:0]         by_q [NS];
  logic signed [ACC_W-1:0] acch_q [NS];
  logic signed [ACC_W-1:0] acct_q [NS];

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      bx_q[0]   <= bx_i;
      by_q[0]   <= by_i;
      acch_q[0] <= acch_i;
      acct_q[0] <= acct_i;
    end
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) begin
        bx_q[k] <= bx_q[k-1];
        by_q[k] <= by_q[k-1];
      end
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (rdy[k]) begin
        acch_q[k] <= acch_q[k-1];
        acct_q[k] <= acct_q[k-1];
      end
    end
    if (rdy[NS-1]) begin
      acch_q[NS-1] <= acch_q[NS-2] + term6[0];
      acct_q[NS-1] <= acct_q[NS-2] + term6[1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NS-1];
  assign bx_o        = bx_q[NS-1];
  assign by_o        = by_q[NS-1];
  assign acch_o      = acch_q[NS-1];
  assign acct_o      = acct_q[NS-1];

endmodule

>>> src/fvnb_level.sv
// ----------------------------------------------------------------------------
// fvnb_level
// Quantizes both octave sums to levels 0..7, looks up the biome and holds
// the result item in the output register.
// ----------------------------------------------------------------------------
module fvnb_level #(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 16,
  parameter int ACC_W       = 35,
  parameter int NW          = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [NW-1:0]           n_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [ACC_W-1:0] acch_i,
  input  logic signed [ACC_W-1:0] acct_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output fvnb_pkg::out_item_t     out_item_o
);

  localparam int TW = ACC_W + 3;

  // thresholds j*(2^n-1)*2^(2K-n-1+F), matching 8*|sum| against j*divisor
  logic [TW-1:0] th_d [7];
  logic [TW-1:0] th_q [7];

  always_comb begin
    logic [TW-1:0] mask;
    int            sh;
    mask = (TW'(1) << n_i) - TW'(1);
    sh   = 2 * MAX_OCTAVES - 1 + FRAC_BITS - int'(n_i);
    for (int j = 0; j < 7; j++) begin
      th_d[j] = (TW'(j + 1) * mask) << sh;
    end
  end

  always_ff @(posedge clk_i) begin
    th_q <= th_d;
  end

  logic [TW-1:0] mh8, mt8;
  logic [2:0]    hl, tl;

  assign mh8 = TW'(acch_i < 0 ? ACC_W'(-acch_i) : ACC_W'(acch_i)) << 3;
  assign mt8 = TW'(acct_i < 0 ? ACC_W'(-acct_i) : ACC_W'(acct_i)) << 3;

  always_comb begin
    hl = '0;
    tl = '0;
    for (int j = 0; j < 7; j++) begin
      if (mh8 >= th_q[j]) hl = hl + 3'd1;
      if (mt8 >= th_q[j]) tl = tl + 3'd1;
    end
  end

  logic                valid_q;
  fvnb_pkg::out_item_t item_q;

  assign in_ready_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      item_q.biome_code   <= fvnb_pkg::BIOME_ROM[{tl, hl}];
      item_q.height_level <= hl;
      item_q.temp_level   <= tl;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

>>> src/fractal_value_noise_biome_map.sv
// ----------------------------------------------------------------------------
// fractal_value_noise_biome_map
// Biome class of one world tile from two fields of fractal value noise.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries one tile coordinate pair per
//   item; output channel out_valid_o/out_ready_i returns one biome item per
//   tile, in order.
//   Configuration: write cfg_data_i to register cfg_idx_i when cfg_we_i is
//   high (height seed, temperature seed, base frequency, octave count); only
//   while the block is idle.
//   Pipeline: the scaling stage, one seven-stage cell per octave and the
//   level/output stage.
//   Cells for octaves beyond the configured count pass the sums unchanged.
//   Throughput: one item per cycle unless stalled; every stage has a valid bit.
//   Stall: when out_ready_i is low, items pack into empty stages behind the
//   held result and in_ready_o drops only once the whole chain is full.
//   Reset: registers return to their reset values, the chain is emptied;
//   the biome ROM is constant.
// ----------------------------------------------------------------------------
module fractal_value_noise_biome_map #(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fvnb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fvnb_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  fvnb_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output fvnb_pkg::out_item_t               out_item_o
);

  `include "fractal_value_noise_biome_map_assert.svh"

  localparam int K     = MAX_OCTAVES;
  localparam int NW    = $clog2(K + 1);
  localparam int BX_W  = fvnb_pkg::COORD_BITS + ((FRAC_BITS > 16) ? FRAC_BITS : 16);
  localparam int ACC_W = FRAC_BITS + 2 * K + 3;

  // configuration registers
  logic [31:0] height_seed_q, temp_seed_q;
  logic [15:0] noise_freq_q;
  logic [3:0]  octave_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_seed_q  <= 32'd0;
      temp_seed_q    <= 32'd0;
      noise_freq_q   <= 16'd2294;
      octave_count_q <= 4'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fvnb_pkg::REG_HEIGHT_SEED:  height_seed_q  <= cfg_data_i[31:0];
        fvnb_pkg::REG_TEMP_SEED:    temp_seed_q    <= cfg_data_i[31:0];
        fvnb_pkg::REG_NOISE_FREQ:   noise_freq_q   <= cfg_data_i[15:0];
        fvnb_pkg::REG_OCTAVE_COUNT: octave_count_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  logic [NW-1:0] n_eff;
  logic [31:0]   hseed, tseed;

  assign n_eff = (octave_count_q == 4'd0) ? NW'(1) :
                 (int'(octave_count_q) > K) ? NW'(K) : NW'(octave_count_q);
  assign hseed = height_seed_q * fvnb_pkg::HASH_MUL_SEED;
  assign tseed = temp_seed_q * fvnb_pkg::HASH_MUL_SEED;

  // octave chain
  logic [K:0]              c_vld, c_rdy;
  logic [BX_W-1:0]         c_bx [K+1];
  logic [BX_W-1:0]         c_by [K+1];
  logic signed [ACC_W-1:0] c_acch [K+1];
  logic signed [ACC_W-1:0] c_acct [K+1];

  fvnb_front #(
    .FRAC_BITS (FRAC_BITS),
    .BX_W      (BX_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .freq_i      (noise_freq_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (c_vld[0]),
    .out_ready_i (c_rdy[0]),
    .bx_o        (c_bx[0]),
    .by_o        (c_by[0])
  );

  assign c_acch[0] = '0;
  assign c_acct[0] = '0;

  for (genvar i = 0; i < K; i++) begin : g_cell
    fvnb_cell #(
      .MAX_OCTAVES (K),
      .FRAC_BITS   (FRAC_BITS),
      .OCT         (i),
      .BX_W        (BX_W),
      .ACC_W       (ACC_W),
      .NW          (NW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .n_i         (n_eff),
      .hseed_i     (hseed),
      .tseed_i     (tseed),
      .in_valid_i  (c_vld[i]),
      .in_ready_o  (c_rdy[i]),
      .bx_i        (c_bx[i]),
      .by_i        (c_by[i]),
      .acch_i      (c_acch[i]),
      .acct_i      (c_acct[i]),
      .out_valid_o (c_vld[i+1]),
      .out_ready_i (c_rdy[i+1]),
      .bx_o        (c_bx[i+1]),
      .by_o        (c_by[i+1]),
      .acch_o      (c_acch[i+1]),
      .acct_o      (c_acct[i+1])
    );
  end

  fvnb_level #(
    .MAX_OCTAVES (K),
    .FRAC_BITS   (FRAC_BITS),
    .ACC_W       (ACC_W),
    .NW          (NW)
  ) u_level (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_i         (n_eff),
    .in_valid_i  (c_vld[K]),
    .in_ready_o  (c_rdy[K]),
    .acch_i      (c_acch[K]),
    .acct_i      (c_acct[K]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  `FVNB_ASSERT_IMPLIES(a_biome_rom, out_valid_o, out_item_o.biome_code == fvnb_pkg::BIOME_ROM[{out_item_o.temp_level, out_item_o.height_level}], "biome code does not match levels")
  `FVNB_ASSERT_IMPLIES(a_oct_range, 1'b1, (n_eff >= NW'(1)) && (n_eff <= NW'(K)), "octave count out of range")
  `FVNB_ASSERT_NEXT(a_front_load, in_valid_i && in_ready_o, c_vld[0], "accepted item lost at front")

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the noise biome block against a local bit-exact predictor. Tiles are
// sent in bursts with random gaps while the output side stalls on its own
// pattern. The block is reconfigured between phases, including the extremes.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CB         = fvnb_pkg::COORD_BITS;
  localparam int FRAC       = 16;
  localparam int LATENCY    = 7 * 8 + 2;
  localparam longint ONE_Q  = 64'sd65536;
  localparam longint C11    = 64'sd72090;  // round(1.1 * 2^16)

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [fvnb_pkg::CFG_IDX_W-1:0]  cfg_idx = fvnb_pkg::REG_HEIGHT_SEED;
  logic [fvnb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  fvnb_pkg::in_item_t              in_item = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  fvnb_pkg::out_item_t             out_item;

  fractal_value_noise_biome_map DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  // shadow copy of the block's registers
  logic [31:0] height_seed = 32'd0;
  logic [31:0] temp_seed   = 32'd0;
  logic [15:0] noise_freq  = 16'd2294;
  logic [3:0]  octave_cnt  = 4'd4;

  fvnb_pkg::in_item_t  tile_queue[$];
  fvnb_pkg::out_item_t biome_queue[$];
  int                  errors = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------- predictor ----------------
  function automatic longint lattice_val(logic [31:0] x, logic [31:0] y, logic [31:0] seed);
    logic [31:0] n;
    logic [31:0] m;
    n = x + y * fvnb_pkg::HASH_MUL_Y + seed * fvnb_pkg::HASH_MUL_SEED;
    n = (n << 13) ^ n;
    m = (n * (n * n * fvnb_pkg::HASH_MUL_SQ + fvnb_pkg::HASH_ADD_SQ)
         + fvnb_pkg::HASH_ADD_OUT) & 32'h7fffffff;
    return ONE_Q - longint'({32'd0, m >> (30 - FRAC)});
  endfunction

  function automatic logic [63:0] smooth_weight(logic [63:0] s);
    logic [63:0] s2;
    s2 = (s * s) >> FRAC;
    return (s2 * (64'd196608 - 64'd2 * s)) >> FRAC;
  endfunction

  function automatic longint lerp_floor(longint a, longint b, logic [63:0] w);
    longint p;
    p = (b - a) * longint'(w);
    return a + (p >>> FRAC);
  endfunction

  function automatic longint value_noise(logic [63:0] px, logic [63:0] py, logic [31:0] seed);
    logic [31:0] xi;
    logic [31:0] yi;
    logic [63:0] wx;
    logic [63:0] wy;
    longint      lo;
    longint      hi;
    xi = px[FRAC+31:FRAC];
    yi = py[FRAC+31:FRAC];
    wx = smooth_weight({48'd0, px[FRAC-1:0]});
    wy = smooth_weight({48'd0, py[FRAC-1:0]});
    lo = lerp_floor(lattice_val(xi, yi, seed), lattice_val(xi + 1, yi, seed), wx);
    hi = lerp_floor(lattice_val(xi, yi + 1, seed), lattice_val(xi + 1, yi + 1, seed), wx);
    return lerp_floor(lo, hi, wy);
  endfunction

  function automatic logic [2:0] noise_level(logic [63:0] bx, logic [63:0] by,
                                             logic [31:0] seed, int n);
    longint      acc;
    longint      t;
    logic [63:0] mag;
    logic [63:0] den;
    logic [63:0] q;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      t = value_noise(bx << i, by << i, seed) + C11;
      acc += t <<< (2 * n - 2 - i);
      acc -= ONE_Q <<< (2 * n - 2 - 2 * i);
    end
    mag = (acc < 0) ? 64'(-acc) : 64'(acc);
    den = ((((64'd1 << n) - 64'd1) << (n - 1)) << FRAC);
    q = (mag * 64'd8) / den;
    return (q > 64'd7) ? 3'd7 : q[2:0];
  endfunction

  function automatic logic [63:0] tile_mag(logic [CB-1:0] v);
    // most negative coordinate maps to 2^(CB-1)
    if (v[CB-1]) return (64'd1 << CB) - {40'd0, v};
    return {40'd0, v};
  endfunction

  function automatic fvnb_pkg::out_item_t predict_biome(fvnb_pkg::in_item_t it);
    fvnb_pkg::out_item_t r;
    logic [63:0]         bx;
    logic [63:0]         by;
    int                  n;
    bx = tile_mag(it.tile_x) * {48'd0, noise_freq};
    by = tile_mag(it.tile_y) * {48'd0, noise_freq};
    n = int'(octave_cnt);
    if (n < 1) n = 1;
    if (n > 8) n = 8;
    r.height_level = noise_level(bx, by, height_seed, n);
    r.temp_level   = noise_level(bx, by, temp_seed, n);
    r.biome_code   = fvnb_pkg::BIOME_ROM[{r.temp_level, r.height_level}];
    return r;
  endfunction

  // ---------------- driver ----------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    logic accepted;
    if (rst_ni) begin
      accepted = in_valid && in_ready;
      if (accepted) biome_queue.push_back(predict_biome(in_item));
      if (!in_valid || accepted) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (tile_queue.size() > 0) begin
          in_item  <= tile_queue.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  int stall_mode = 0;
  int stall_cnt = 0;

  always @(posedge clk_i) begin
    fvnb_pkg::out_item_t want;
    logic                rdy;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (biome_queue.size() == 0) begin
          $display("%0t: unexpected item %p", $time, out_item);
          errors++;
        end else begin
          want = biome_queue.pop_front();
          if (out_item.biome_code !== want.biome_code) begin
            $display("%0t: biome_code expected %0d actual %0d", $time,
                     want.biome_code, out_item.biome_code);
            errors++;
          end
          if (out_item.height_level !== want.height_level) begin
            $display("%0t: height_level expected %0d actual %0d", $time,
                     want.height_level, out_item.height_level);
            errors++;
          end
          if (out_item.temp_level !== want.temp_level) begin
            $display("%0t: temp_level expected %0d actual %0d", $time,
                     want.temp_level, out_item.temp_level);
            errors++;
          end
        end
      end
      if (stall_cnt == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_cnt  = $urandom_range(20, 150);
      end else stall_cnt--;
      case (stall_mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 1) == 1);
        2: rdy = (stall_cnt % 5 != 0);
        default: rdy = ($urandom_range(0, 7) == 0);
      endcase
      out_ready <= rdy;
    end
  end

  // ---------------- stimulus ----------------
  task automatic write_reg(logic [fvnb_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      fvnb_pkg::REG_HEIGHT_SEED:  height_seed = data;
      fvnb_pkg::REG_TEMP_SEED:    temp_seed   = data;
      fvnb_pkg::REG_NOISE_FREQ:   noise_freq  = data[15:0];
      fvnb_pkg::REG_OCTAVE_COUNT: octave_cnt  = data[3:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [31:0] hs, logic [31:0] ts, logic [31:0] fr, logic [31:0] oc);
    write_reg(fvnb_pkg::REG_HEIGHT_SEED, hs);
    write_reg(fvnb_pkg::REG_TEMP_SEED, ts);
    write_reg(fvnb_pkg::REG_NOISE_FREQ, fr);
    write_reg(fvnb_pkg::REG_OCTAVE_COUNT, oc);
  endtask

  task automatic drain();
    while (tile_queue.size() > 0 || in_valid || biome_queue.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  function automatic logic [CB-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return CB'($urandom);
      1: return CB'($urandom_range(0, 255)) ^ {CB{$urandom_range(0, 1) == 1}};
      2: return ($urandom_range(0, 1) == 1) ? 24'h800000 : 24'h7fffff;
      default: return CB'($signed($urandom_range(0, 8000)) - 4000);
    endcase
  endfunction

  task automatic add_random(int count);
    fvnb_pkg::in_item_t it;
    for (int k = 0; k < count; k++) begin
      it.tile_x = rand_coord();
      it.tile_y = rand_coord();
      tile_queue.push_back(it);
    end
  endtask

  task automatic add_tile(logic [CB-1:0] x, logic [CB-1:0] y);
    fvnb_pkg::in_item_t it;
    it.tile_x = x;
    it.tile_y = y;
    tile_queue.push_back(it);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset defaults first, directed corners
    add_tile(24'h000000, 24'h000000);
    add_tile(24'h7fffff, 24'h7fffff);
    add_tile(24'h800000, 24'h800000);
    add_tile(24'h800000, 24'h7fffff);
    add_tile(24'hffffff, 24'h000001);
    add_tile(24'h000001, 24'hffffff);
    add_tile(24'h7fffff, 24'h000000);
    add_tile(24'h000000, 24'h800000);
    add_tile(24'h000064, 24'hffff9c);
    add_tile(24'h555555, 24'haaaaaa);
    add_random(10);
    drain();

    // all-ones seeds, max frequency, max octaves
    configure(32'hffffffff, 32'hffffffff, 32'h0000ffff, 32'd8);
    add_random(300);
    drain();

    // zero frequency, octave count zero, upper data bits set
    configure(32'h12345678, 32'h0, 32'hffff0000, 32'hfffffff0);
    add_random(150);
    drain();

    // octave count above the maximum
    configure(32'h0, 32'hdeadbeef, 32'd1, 32'd15);
    add_random(200);
    drain();

    configure(32'h0, 32'h0, 32'd2294, 32'd1);
    add_random(200);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      configure($urandom, $urandom, $urandom, $urandom_range(0, 15));
      add_random(220);
      drain();
    end

    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
